[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/lnds_pkg.sv]
// package for the longest non-decreasing subsequence block
// constants and word types, no dependencies
package lnds_pkg;

    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_BITS  = $clog2(MAX_LEN);
    localparam int LEN_BITS   = ADDR_BITS + 1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  first;
    } item_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] length;
        logic                overflow;
    } result_t;

endpackage

[sv/longest_nondecreasing_subsequence.sv]
// top level of the longest non-decreasing subsequence block
// depends on lnds_pkg, lnds_ram and assert_macros.svh
//
// Streams unsigned values and returns, for every input word, the length of the
// longest non-decreasing subsequence seen since the last word with first set,
// plus an overflow flag when an extension was dropped because the tails table
// (MAX_LEN entries) was already full. The tails table sits in one ram with a
// registered read port, and a single comparator runs a binary search over the
// valid entries, one probe per cycle. A word with zero length goes from idle
// straight to the write state; any other word passes through prime, then one
// compare state per probe until the window closes, then the write state.
// item_stall is high while a word is being worked on. The result sits in an
// output register, so the next word is taken while a result still waits; a
// word stalls at its final write only if the previous result has not been
// taken yet. Table entries are never cleared: only entries below the current
// length are read, and each was written in the current sequence.
module longest_nondecreasing_subsequence (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  lnds_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output lnds_pkg::result_t result
);
    import lnds_pkg::*;

    `include "assert_macros.svh"

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;  // first probe address goes to the ram
    localparam logic [1:0] ST_CMP   = 2'd2;  // compare probe, issue next probe
    localparam logic [1:0] ST_WRITE = 2'd3;  // store the value, load the result

    localparam logic [LEN_BITS-1:0] MAX_LEN_L = LEN_BITS'(MAX_LEN);
    localparam logic [LEN_BITS-1:0] ONE_L     = LEN_BITS'(1);

    logic [1:0]            state_reg, state_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [LEN_BITS-1:0]   lo_reg, lo_next;
    logic [LEN_BITS-1:0]   hi_reg, hi_next;
    logic [LEN_BITS-1:0]   mid_reg, mid_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg, result_next;

    // search datapath
    logic [LEN_BITS-1:0]   len_eff;
    logic [LEN_BITS:0]     sum_cur, sum_cmp;
    logic [LEN_BITS-1:0]   mid_cur, mid_cmp;
    logic [LEN_BITS-1:0]   lo_cmp, hi_cmp;
    logic                  greater;
    logic [VALUE_BITS-1:0] rdata;
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic                  out_busy;

    lnds_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_LEN)
    ) u_tails (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value_reg),
        .raddr (mid_next[ADDR_BITS-1:0]),
        .rdata (rdata)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_busy     = result_valid_reg && result_stall;

    always_comb
    begin
        len_eff = item.first ? '0 : len_reg;

        // midpoint of the current window
        sum_cur = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid_cur = sum_cur[LEN_BITS:1];

        // one search step on the probe that just came back
        greater = (rdata > value_reg);
        lo_cmp  = greater ? lo_reg : (mid_reg + ONE_L);
        hi_cmp  = greater ? mid_reg : hi_reg;
        sum_cmp = {1'b0, lo_cmp} + {1'b0, hi_cmp};
        mid_cmp = sum_cmp[LEN_BITS:1];
    end

    always_comb
    begin
        state_next        = state_reg;
        len_next          = len_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        value_next        = value_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        we                = 1'b0;
        waddr             = lo_reg[ADDR_BITS-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    value_next = item.value;
                    len_next   = len_eff;
                    lo_next    = '0;
                    hi_next    = len_eff;
                    // empty sequence: the value lands in slot zero directly
                    state_next = (len_eff == '0) ? ST_WRITE : ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                mid_next   = mid_cur;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                lo_next = lo_cmp;
                hi_next = hi_cmp;
                if (lo_cmp < hi_cmp)
                begin
                    mid_next = mid_cmp;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_busy)
                begin
                    result_next.overflow = 1'b0;
                    if (lo_reg < len_reg)
                    begin
                        // replace the first tail above the value
                        we = 1'b1;
                    end
                    else if (len_reg < MAX_LEN_L)
                    begin
                        // extend past the end
                        we       = 1'b1;
                        len_next = len_reg + ONE_L;
                    end
                    else
                    begin
                        // table full: drop the value
                        result_next.overflow = 1'b1;
                    end
                    result_next.length = len_next;
                    result_valid_next  = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            len_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        value_reg  <= value_next;
        result_reg <= result_next;
    end

    // length never runs past the table
    `ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, len_reg <= MAX_LEN_L)
    // an overflow is only reported at a full table
    `ASSERT_IMPL(a_ovf_full, clk, rst_n, result_valid && result.overflow, result.length == MAX_LEN_L)
    // while comparing, the search window is never empty
    `ASSERT_IMPL(a_window, clk, rst_n, state_reg == ST_CMP, (lo_reg < hi_reg) && (mid_reg < len_reg))
    // a pending result that is stalled is not overwritten
    `ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

endmodule

[sv/lnds_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module lnds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/longest_nondecreasing_subsequence_test.sv]
`timescale 1ns / 1ps
// testbench for the longest non-decreasing subsequence block
// depends on lnds_pkg and the longest_nondecreasing_subsequence top level
module longest_nondecreasing_subsequence_test;

    import lnds_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 40;    // settle time after the last result
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
    localparam int RANDOM_WORDS   = 100;
    localparam int PRINT_CAP      = 50;

    // value shapes for the random sequences
    typedef enum int {
        SHAPE_SCATTER,
        SHAPE_NARROW,
        SHAPE_RISING,
        SHAPE_FALLING
    } shape_e;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    longest_nondecreasing_subsequence DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // predictor state: own copy of the tails table and the running length
    logic [VALUE_BITS-1:0] tail_tab [0:MAX_LEN-1];
    int                    seq_len;

    result_t expected_results [$];
    result_t oldest_expected;

    int  fail_count;
    int  words_sent;
    int  results_checked;
    int  longest_seen;
    int  overflows_seen;
    int  idle_cycles;

    // idling controls for the sender and the receiver
    bit  tx_idling;
    bit  rx_idling;
    bit  hold_request;
    bit  rx_stall_next;
    int  rx_left;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // patience step: find the first tail strictly above the value among the
    // valid entries, overwrite it, or append when none is greater
    function automatic result_t predict_length(input logic first, input logic [15:0] value);
        int      lo;
        int      hi;
        int      mid;
        result_t r;
        if (first)
            seq_len = 0;
        lo = 0;
        hi = seq_len;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (tail_tab[mid] > value)
                hi = mid;
            else
                lo = mid + 1;
        end
        r.overflow = 1'b0;
        if (lo < seq_len)
            tail_tab[lo] = value;
        else if (seq_len < MAX_LEN)
        begin
            tail_tab[seq_len] = value;
            seq_len++;
        end
        else
            r.overflow = 1'b1;   // table full, extension dropped
        r.length = seq_len[LEN_BITS-1:0];
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // offer one word, wait for it to be taken, record its expected result
    // valid stays high when no gap follows, so back-to-back words never glitch
    task automatic send_word(input logic first, input logic [15:0] value);
        int      gap;
        result_t want;
        item_valid  <= 1'b1;
        item.first  <= first;
        item.value  <= value;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        want             = predict_length(first, value);
        expected_results = {expected_results, want};
        words_sent++;
        gap = tx_idling ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and wait until every outstanding result has been taken
    task automatic pause_until_drained();
        item_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge clk);
    endtask

    // extremes, equal values, replacement, restart over stale tails
    task automatic test_directed_cases();
        send_word(1'b1, 16'h0000);
        send_word(1'b0, 16'h0000);   // equal value extends
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'hFFFF);   // equal at the top extends too
        send_word(1'b0, 16'h0000);   // goes past equal entries, replaces a tail
        send_word(1'b0, 16'h0001);
        send_word(1'b0, 16'h0064);
        send_word(1'b0, 16'h0032);   // decreasing values only replace
        send_word(1'b0, 16'h0019);
        send_word(1'b1, 16'hFFFF);   // restart, stale tails must be ignored
        send_word(1'b0, 16'h0000);
        send_word(1'b1, 16'h0000);   // restart twice in a row
        send_word(1'b1, 16'h0000);
        send_word(1'b0, 16'h5555);
        send_word(1'b0, 16'hAAAA);
        send_word(1'b0, 16'h8000);
        send_word(1'b0, 16'h7FFF);
        send_word(1'b0, 16'h0001);
        send_word(1'b0, 16'hAAAA);
        send_word(1'b0, 16'hFFFE);
        pause_until_drained();
    endtask

    // fill the whole table with a non-decreasing run, then push past it
    task automatic test_table_full();
        int i;
        send_word(1'b1, 16'h0000);
        for (i = 1; i < MAX_LEN; i++)
            send_word(1'b0, 16'(i * 64 + $urandom_range(0, 'h3f)));
        send_word(1'b0, 16'hFFFF);   // extension with a full table
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'h0000);   // replacement still allowed when full
        send_word(1'b0, 16'hFFFF);
        send_word(1'b1, 16'h0007);   // restart drops the length back to one
        send_word(1'b0, 16'h0007);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        int i;
        tx_idling    = 1'b0;
        hold_request = 1'b1;
        send_word(1'b1, 16'($urandom));
        for (i = 0; i < 40; i++)
            send_word(1'b0, 16'($urandom));
        tx_idling = 1'b1;
        pause_until_drained();
    endtask

    // sequences of random shape and length, with random restarts as noise
    task automatic test_random_sequences(input int target);
        int                    n;
        int                    i;
        int                    span;
        shape_e                shape;
        logic [VALUE_BITS-1:0] base;
        logic [VALUE_BITS-1:0] value;
        logic                  first;
        n = 0;
        while (n < target)
        begin
            span      = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250)
                                                    : $urandom_range(1, 30);
            if (span > target - n)
                span = target - n;
            shape     = shape_e'($urandom_range(0, 3));
            tx_idling = ($urandom_range(0, 4) != 0);
            rx_idling = ($urandom_range(0, 4) != 0);
            base      = 16'($urandom);
            for (i = 0; i < span; i++)
            begin
                case (shape)
                    SHAPE_SCATTER: value = 16'($urandom);
                    SHAPE_NARROW:  value = base + 16'($urandom_range(0, 3));
                    SHAPE_RISING:
                    begin
                        value = base;
                        base  = base + 16'($urandom_range(0, 'h3f));
                        if ($urandom_range(0, 7) == 0)
                            value = 16'($urandom);
                    end
                    default:
                    begin
                        value = base;
                        base  = base - 16'($urandom_range(0, 'h3f));
                    end
                endcase
                if (i == 0)
                    first = ($urandom_range(0, 9) != 0);
                else
                    first = ($urandom_range(0, 49) == 0);
                send_word(first, value);
                n++;
            end
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // receiver: random stall phases, a long hold-off on request,
    // or no stalls at all when idling is switched off
    initial
    begin
        result_stall = 1'b0;
        rx_left      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                rx_left      = 0;
                result_stall <= 1'b0;
            end
            else if (rx_left > 0)
                rx_left--;
            else if (!rx_idling)
                result_stall <= 1'b0;
            else
            begin
                rx_stall_next = ($urandom_range(0, 2) == 0);
                result_stall <= rx_stall_next;
                rx_left       = rx_stall_next ? pick_gap() : $urandom_range(0, 8);
            end
        end
    end

    // result checker: every taken result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected, length", result.length, -1);
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result.length !== oldest_expected.length)
                    report_mismatch("length", result.length, oldest_expected.length);
                if (result.overflow !== oldest_expected.overflow)
                    report_mismatch("overflow", result.overflow, oldest_expected.overflow);
                results_checked++;
                if (oldest_expected.length > longest_seen)
                    longest_seen = oldest_expected.length;
                if (oldest_expected.overflow)
                    overflows_seen++;
            end
        end
    end

    // watchdog: a long run of cycles with no handshake on either side ends the run
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_results.size());
        $display("simulation failed");
        $finish;
    end

    // main sequence: reset once, then each test in turn
    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        item            = '0;
        seq_len         = 0;
        fail_count      = 0;
        words_sent      = 0;
        results_checked = 0;
        longest_seen    = 0;
        overflows_seen  = 0;
        tx_idling       = 1'b1;
        rx_idling       = 1'b1;
        hold_request    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_backpressure();
        test_table_full();
        pause_until_drained();
        test_random_sequences(RANDOM_WORDS);

        // all words taken: wait for the last results, then let the block settle
        item_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words and checked %0d results, %0d mismatches",
                 words_sent, results_checked, fail_count);
        $display("longest run reached %0d, %0d dropped extensions on a full table",
                 longest_seen, overflows_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
